// ===== rtl/gspe_pkg.sv =====
// ----------------------------------------------------------------------------
// gspe_pkg
// Shared types, codes, constants and constant tables of the gas sensor
// concentration estimator.
// ----------------------------------------------------------------------------
package gspe_pkg;

  localparam int READ_SAMPLES   = 8;
  localparam int CAL_SAMPLES    = 64;
  localparam int ADC_FULL_SCALE = 1023;

  localparam int ADC_FS_W   = 12;
  localparam int SUM_W      = 40;
  localparam int COUNT_W    = 7;
  localparam int DIV_N_W    = 48;
  localparam int DIV_D_W    = 32;
  localparam int EXP_STEPS  = 16;
  localparam int GAS_COUNT  = 3;

  localparam logic [ADC_FS_W-1:0] ADC_FS = ADC_FS_W'(ADC_FULL_SCALE);
  localparam logic signed [15:0]  LOG10_2_Q16 = 16'sd19728;
  localparam logic signed [18:0]  LOG2_10_Q16 = 19'sd217706;

  // request codes
  localparam logic [1:0] REQ_CAL   = 2'd0;
  localparam logic [1:0] REQ_MEAS  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_READY    = 2'd0;
  localparam logic [1:0] STATUS_CAL_DONE = 2'd1;
  localparam logic [1:0] STATUS_NOT_CAL  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_LPG_CURVE   = 3'd0;
  localparam logic [2:0] REG_CO_CURVE    = 3'd1;
  localparam logic [2:0] REG_SMOKE_CURVE = 3'd2;
  localparam logic [2:0] REG_LOAD_RES    = 3'd3;
  localparam logic [2:0] REG_CLEAN_AIR   = 3'd4;

  localparam logic [15:0] LOAD_RES_RESET  = 16'd1280;
  localparam logic [15:0] CLEAN_AIR_RESET = 16'd2516;

  typedef struct packed {
    logic [47:0] lpg_curve;
    logic [47:0] co_curve;
    logic [47:0] smoke_curve;
    logic [15:0] load_resistance;
    logic [15:0] clean_air_factor;
  } gspe_cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_NOCAL,
    OP_SAMPLE,
    OP_ACCUM,
    OP_MEAN,
    OP_RO_DIV,
    OP_RO_SET,
    OP_RATIO_DIV,
    OP_RATIO_SET,
    OP_NORM,
    OP_LOG_INIT,
    OP_LOG_STEP,
    OP_LOG_SCALE,
    OP_GAS_START,
    OP_GAS_SIGN,
    OP_GAS_MUL,
    OP_GAS_CHECK,
    OP_EXP_STEP,
    OP_GAS_FINISH,
    OP_GAS_NEXT,
    OP_EMIT
  } gspe_op_t;

  typedef struct packed {
    logic [1:0] req;
    logic       is_cal;
    logic       kind;
    logic       window_full;
    logic       div_done;
    logic       norm_done;
    logic       log_last;
    logic       slope_zero;
    logic       f_sat;
    logic       f_small;
    logic       exp_last;
    logic       gas_last;
    logic       out_free;
  } gspe_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_SAMPLE_WAIT,
    S_CHECK,
    S_MEAN_WAIT,
    S_RO_WAIT,
    S_RATIO_WAIT,
    S_NORM,
    S_LOG,
    S_SCALE,
    S_GAS_START,
    S_GAS_WAIT,
    S_GAS_MUL,
    S_GAS_CHECK,
    S_EXP,
    S_GAS_FINISH,
    S_GAS_NEXT,
    S_EMIT
  } gspe_state_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int n = 0; n < 32; n++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q30 value of 2^(2^-k)
  function automatic logic [31:0] exp2_root(input int k);
    logic [63:0] s;
    s = 64'h8000_0000;
    for (int n = 1; n <= k; n++) begin
      s = isqrt64(s << 30);
    end
    return s[31:0];
  endfunction

  localparam logic [31:0] EXP2_ROOT [EXP_STEPS] = '{
    exp2_root(1),  exp2_root(2),  exp2_root(3),  exp2_root(4),
    exp2_root(5),  exp2_root(6),  exp2_root(7),  exp2_root(8),
    exp2_root(9),  exp2_root(10), exp2_root(11), exp2_root(12),
    exp2_root(13), exp2_root(14), exp2_root(15), exp2_root(16)
  };

endpackage

// ===== rtl/gspe_div.sv =====
// ----------------------------------------------------------------------------
// gspe_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gspe_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gspe_pkg::DIV_N_W-1:0]  dividend,
  input  logic [gspe_pkg::DIV_D_W-1:0]  divisor,
  output logic                          done,
  output logic [gspe_pkg::DIV_N_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(gspe_pkg::DIV_N_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(gspe_pkg::DIV_N_W - 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [gspe_pkg::DIV_D_W-1:0]  rem;
  logic [gspe_pkg::DIV_D_W-1:0]  dvs;
  logic [gspe_pkg::DIV_D_W:0]    trial;
  logic                          qbit;

  assign trial = {rem, quotient[gspe_pkg::DIV_N_W-1]};
  assign qbit  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= qbit ? gspe_pkg::DIV_D_W'(trial - {1'b0, dvs})
                       : trial[gspe_pkg::DIV_D_W-1:0];
      quotient <= {quotient[gspe_pkg::DIV_N_W-2:0], qbit};
    end
  end

endmodule

// ===== rtl/gspe_datapath.sv =====
// ----------------------------------------------------------------------------
// gspe_datapath
// Window accumulation, Ro and ratio, log10, per-gas exponent and the result
// register, driven one operation per cycle by the controller.
// ----------------------------------------------------------------------------
module gspe_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  gspe_pkg::gspe_op_t   op,
  input  gspe_pkg::gspe_cfg_t  cfg,
  output gspe_pkg::gspe_stat_t st,
  input  logic [1:0]           req_type,
  input  logic [9:0]           adc_sample,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [1:0]           status,
  output logic [31:0]          lpg_ppm,
  output logic [31:0]          co_ppm,
  output logic [31:0]          smoke_ppm,
  output logic [31:0]          ro_kohm,
  output logic                 saturated
);

  localparam logic [31:0] U32MAX = '1;

  // item and window
  logic [1:0]                     req_q;
  logic [9:0]                     adc_q;
  logic [gspe_pkg::SUM_W-1:0]     sum;
  logic [gspe_pkg::COUNT_W-1:0]   count;
  logic                           kind;
  logic                           wsat;
  logic [31:0]                    ro;
  logic                           cal;
  logic                           sat_work;
  logic [1:0]                     status_work;

  // log10 and exponent
  logic [31:0]                    x;
  logic [4:0]                     p;
  logic [15:0]                    frac;
  logic [3:0]                     i;
  logic signed [21:0]             lg;
  logic [1:0]                     g;
  logic                           neg;
  logic signed [23:0]             e;
  logic signed [26:0]             f;
  logic [30:0]                    m;
  logic [3:0]                     j;
  logic [31:0]                    ppm_work [gspe_pkg::GAS_COUNT];

  // divider
  logic                           div_start;
  logic [gspe_pkg::DIV_N_W-1:0]   div_n;
  logic [gspe_pkg::DIV_D_W-1:0]   div_d;
  logic                           div_done;
  logic [gspe_pkg::DIV_N_W-1:0]   div_q;

  gspe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // combinational terms
  logic [gspe_pkg::ADC_FS_W-1:0]  diff;
  logic [27:0]                    samp_prod;
  logic                           q_ovf;
  logic [31:0]                    q_sat;
  logic [61:0]                    sq;
  logic [31:0]                    t;
  logic [5:0]                     p_s;
  logic signed [21:0]             l2;
  logic signed [37:0]             lg_prod;
  logic [47:0]                    curve;
  logic signed [15:0]             x0;
  logic signed [15:0]             y0;
  logic signed [15:0]             slope;
  logic [15:0]                    slope_mag;
  logic signed [22:0]             dnum;
  logic [34:0]                    gas_num;
  logic [34:0]                    gas_mag;
  logic [36:0]                    qz;
  logic [36:0]                    qs;
  logic [37:0]                    e38;
  logic                           e_in_range;
  logic signed [42:0]             f_prod;
  logic signed [10:0]             n;
  logic signed [10:0]             sh;
  logic [62:0]                    exp_prod;
  logic [31:0]                    ppm_fin;

  assign diff = ({2'b0, adc_q} < gspe_pkg::ADC_FS)
              ? gspe_pkg::ADC_FS - {2'b0, adc_q} : '0;
  assign samp_prod = cfg.load_resistance * diff;
  assign q_ovf = |div_q[gspe_pkg::DIV_N_W-1:32];
  assign q_sat = q_ovf ? U32MAX : div_q[31:0];

  assign sq = x[30:0] * x[30:0];
  assign t  = sq[61:30];
  assign p_s = {1'b0, p} - 6'd16;
  assign l2 = $signed({p_s, frac});
  assign lg_prod = l2 * gspe_pkg::LOG10_2_Q16;

  always_comb begin
    case (g)
      2'd0:    curve = cfg.lpg_curve;
      2'd1:    curve = cfg.co_curve;
      default: curve = cfg.smoke_curve;
    endcase
  end

  assign x0 = $signed(curve[15:0]);
  assign y0 = $signed(curve[31:16]);
  assign slope = $signed(curve[47:32]);
  assign slope_mag = slope[15] ? (~curve[47:32] + 16'd1) : curve[47:32];
  assign dnum = $signed({lg[21], lg}) - $signed({{3{y0[15]}}, y0, 4'b0});
  assign gas_num = {dnum, 12'b0};
  assign gas_mag = dnum[22] ? (~gas_num + 35'd1) : gas_num;

  assign qz  = {1'b0, div_q[35:0]};
  assign qs  = neg ? (~qz + 37'd1) : qz;
  assign e38 = {qs[36], qs} + {{18{x0[15]}}, x0, 4'b0};
  assign e_in_range = (&e38[37:23]) | ~(|e38[37:23]);
  assign f_prod = e * gspe_pkg::LOG2_10_Q16;
  assign n = f[26:16];
  assign sh = 11'sd18 - n;
  assign exp_prod = m * gspe_pkg::EXP2_ROOT[j];

  always_comb begin
    if (n >= 11'sd18) begin
      ppm_fin = (n == 11'sd19) ? {m, 1'b0} : {1'b0, m};
    end else begin
      ppm_fin = {1'b0, m} >> sh[4:0];
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    unique case (op)
      gspe_pkg::OP_SAMPLE: begin
        div_start = 1'b1;
        div_n     = gspe_pkg::DIV_N_W'({samp_prod, 8'b0});
        div_d     = gspe_pkg::DIV_D_W'(adc_q);
      end
      gspe_pkg::OP_MEAN: begin
        div_start = 1'b1;
        div_n     = gspe_pkg::DIV_N_W'(sum);
        div_d     = kind ? gspe_pkg::DIV_D_W'(gspe_pkg::READ_SAMPLES)
                         : gspe_pkg::DIV_D_W'(gspe_pkg::CAL_SAMPLES);
      end
      gspe_pkg::OP_RO_DIV: begin
        div_start = 1'b1;
        div_n     = {div_q[39:0], 8'b0};
        div_d     = gspe_pkg::DIV_D_W'(cfg.clean_air_factor);
      end
      gspe_pkg::OP_RATIO_DIV: begin
        div_start = 1'b1;
        div_n     = {q_sat, 16'b0};
        div_d     = ro;
      end
      gspe_pkg::OP_GAS_START: begin
        div_start = (slope != 16'sd0);
        div_n     = gspe_pkg::DIV_N_W'(gas_mag);
        div_d     = gspe_pkg::DIV_D_W'(slope_mag);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      sum          <= '0;
      count        <= '0;
      kind         <= 1'b0;
      wsat         <= 1'b0;
      ro           <= '0;
      cal          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (op)
        gspe_pkg::OP_CLEAR: begin
          ro    <= '0;
          cal   <= 1'b0;
          sum   <= '0;
          count <= '0;
          kind  <= 1'b0;
          wsat  <= 1'b0;
        end
        gspe_pkg::OP_SAMPLE: begin
          if ((req_q == gspe_pkg::REQ_MEAS) != kind) begin
            sum   <= '0;
            count <= '0;
            kind  <= (req_q == gspe_pkg::REQ_MEAS);
            wsat  <= 1'b0;
          end
        end
        gspe_pkg::OP_ACCUM: begin
          if (adc_q == 10'd0) begin
            sum  <= sum + gspe_pkg::SUM_W'(U32MAX);
            wsat <= 1'b1;
          end else begin
            sum  <= sum + gspe_pkg::SUM_W'(q_sat);
            wsat <= wsat | q_ovf;
          end
          count <= count + gspe_pkg::COUNT_W'(1);
        end
        gspe_pkg::OP_RO_SET: begin
          ro    <= (cfg.clean_air_factor == 16'd0) ? U32MAX : q_sat;
          cal   <= 1'b1;
          sum   <= '0;
          count <= '0;
          kind  <= 1'b0;
          wsat  <= 1'b0;
        end
        gspe_pkg::OP_RATIO_SET: begin
          sum   <= '0;
          count <= '0;
          kind  <= 1'b1;
          wsat  <= 1'b0;
        end
        gspe_pkg::OP_EMIT: begin
          result_valid <= 1'b1;
        end
        default: begin
          kind <= kind;
        end
      endcase
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    unique case (op)
      gspe_pkg::OP_LOAD: begin
        req_q <= req_type;
        adc_q <= adc_sample;
      end
      gspe_pkg::OP_NOCAL: begin
        status_work <= gspe_pkg::STATUS_NOT_CAL;
        sat_work    <= 1'b0;
      end
      gspe_pkg::OP_MEAN: begin
        sat_work <= wsat;
      end
      gspe_pkg::OP_RO_SET: begin
        status_work <= gspe_pkg::STATUS_CAL_DONE;
        if (cfg.clean_air_factor == 16'd0 || q_ovf) begin
          sat_work <= 1'b1;
        end
      end
      gspe_pkg::OP_RATIO_SET: begin
        status_work <= gspe_pkg::STATUS_READY;
        p           <= 5'd31;
        if (ro == 32'd0 || q_ovf) begin
          x        <= U32MAX;
          sat_work <= 1'b1;
        end else begin
          x <= (div_q[31:0] == 32'd0) ? 32'd1 : div_q[31:0];
        end
      end
      gspe_pkg::OP_NORM: begin
        x <= {x[30:0], 1'b0};
        p <= p - 5'd1;
      end
      gspe_pkg::OP_LOG_INIT: begin
        x    <= {1'b0, x[31:1]};
        frac <= '0;
        i    <= 4'd15;
      end
      gspe_pkg::OP_LOG_STEP: begin
        x       <= t[31] ? {1'b0, t[31:1]} : t;
        frac[i] <= t[31];
        i       <= i - 4'd1;
      end
      gspe_pkg::OP_LOG_SCALE: begin
        lg <= lg_prod[37:16];
        g  <= '0;
      end
      gspe_pkg::OP_GAS_START: begin
        neg <= dnum[22] ^ slope[15];
        if (slope == 16'sd0) begin
          ppm_work[g] <= U32MAX;
          sat_work    <= 1'b1;
        end
      end
      gspe_pkg::OP_GAS_SIGN: begin
        e <= e_in_range ? $signed(e38[23:0])
                        : (e38[37] ? 24'sh800000 : 24'sh7FFFFF);
      end
      gspe_pkg::OP_GAS_MUL: begin
        f <= f_prod[42:16];
      end
      gspe_pkg::OP_GAS_CHECK: begin
        m <= 31'h4000_0000;
        j <= '0;
        if (n >= 11'sd20) begin
          ppm_work[g] <= U32MAX;
          sat_work    <= 1'b1;
        end else if (n < -11'sd13) begin
          ppm_work[g] <= '0;
        end
      end
      gspe_pkg::OP_EXP_STEP: begin
        if (f[4'(gspe_pkg::EXP_STEPS - 1) - j]) begin
          m <= exp_prod[60:30];
        end
        j <= j + 4'd1;
      end
      gspe_pkg::OP_GAS_FINISH: begin
        ppm_work[g] <= ppm_fin;
      end
      gspe_pkg::OP_GAS_NEXT: begin
        g <= g + 2'd1;
      end
      gspe_pkg::OP_EMIT: begin
        status    <= status_work;
        saturated <= sat_work;
        ro_kohm   <= ro;
        if (status_work == gspe_pkg::STATUS_READY) begin
          lpg_ppm   <= ppm_work[0];
          co_ppm    <= ppm_work[1];
          smoke_ppm <= ppm_work[2];
        end else begin
          lpg_ppm   <= '0;
          co_ppm    <= '0;
          smoke_ppm <= '0;
        end
      end
      default: begin
        g <= g;
      end
    endcase
  end

  always_comb begin
    st.req         = req_q;
    st.is_cal      = cal;
    st.kind        = kind;
    st.window_full = kind ? (count >= gspe_pkg::COUNT_W'(gspe_pkg::READ_SAMPLES))
                          : (count >= gspe_pkg::COUNT_W'(gspe_pkg::CAL_SAMPLES));
    st.div_done    = div_done;
    st.norm_done   = x[31];
    st.log_last    = (i == 4'd0);
    st.slope_zero  = (slope == 16'sd0);
    st.f_sat       = (n >= 11'sd20);
    st.f_small     = (n < -11'sd13);
    st.exp_last    = (j == 4'(gspe_pkg::EXP_STEPS - 1));
    st.gas_last    = (g == 2'(gspe_pkg::GAS_COUNT - 1));
    st.out_free    = !result_valid || result_ready;
  end

endmodule

// ===== rtl/gspe_ctrl.sv =====
// ----------------------------------------------------------------------------
// gspe_ctrl
// Sequencer: walks each sample through the datapath operations.
// ----------------------------------------------------------------------------
module gspe_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  gspe_pkg::gspe_stat_t st,
  output gspe_pkg::gspe_op_t   op
);

  gspe_pkg::gspe_state_t state;
  gspe_pkg::gspe_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gspe_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    op           = gspe_pkg::OP_NONE;
    sample_ready = 1'b0;
    unique case (state)
      gspe_pkg::S_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          op         = gspe_pkg::OP_LOAD;
          state_next = gspe_pkg::S_DECODE;
        end
      end
      gspe_pkg::S_DECODE: begin
        unique case (st.req)
          gspe_pkg::REQ_CLEAR: begin
            op         = gspe_pkg::OP_CLEAR;
            state_next = gspe_pkg::S_IDLE;
          end
          gspe_pkg::REQ_CAL, gspe_pkg::REQ_MEAS: begin
            if (st.req == gspe_pkg::REQ_MEAS && !st.is_cal) begin
              op         = gspe_pkg::OP_NOCAL;
              state_next = gspe_pkg::S_EMIT;
            end else begin
              op         = gspe_pkg::OP_SAMPLE;
              state_next = gspe_pkg::S_SAMPLE_WAIT;
            end
          end
          default: begin
            state_next = gspe_pkg::S_IDLE;
          end
        endcase
      end
      gspe_pkg::S_SAMPLE_WAIT: begin
        if (st.div_done) begin
          op         = gspe_pkg::OP_ACCUM;
          state_next = gspe_pkg::S_CHECK;
        end
      end
      gspe_pkg::S_CHECK: begin
        if (st.window_full) begin
          op         = gspe_pkg::OP_MEAN;
          state_next = gspe_pkg::S_MEAN_WAIT;
        end else begin
          state_next = gspe_pkg::S_IDLE;
        end
      end
      gspe_pkg::S_MEAN_WAIT: begin
        if (st.div_done) begin
          if (st.kind) begin
            op         = gspe_pkg::OP_RATIO_DIV;
            state_next = gspe_pkg::S_RATIO_WAIT;
          end else begin
            op         = gspe_pkg::OP_RO_DIV;
            state_next = gspe_pkg::S_RO_WAIT;
          end
        end
      end
      gspe_pkg::S_RO_WAIT: begin
        if (st.div_done) begin
          op         = gspe_pkg::OP_RO_SET;
          state_next = gspe_pkg::S_EMIT;
        end
      end
      gspe_pkg::S_RATIO_WAIT: begin
        if (st.div_done) begin
          op         = gspe_pkg::OP_RATIO_SET;
          state_next = gspe_pkg::S_NORM;
        end
      end
      gspe_pkg::S_NORM: begin
        if (st.norm_done) begin
          op         = gspe_pkg::OP_LOG_INIT;
          state_next = gspe_pkg::S_LOG;
        end else begin
          op = gspe_pkg::OP_NORM;
        end
      end
      gspe_pkg::S_LOG: begin
        op = gspe_pkg::OP_LOG_STEP;
        if (st.log_last) begin
          state_next = gspe_pkg::S_SCALE;
        end
      end
      gspe_pkg::S_SCALE: begin
        op         = gspe_pkg::OP_LOG_SCALE;
        state_next = gspe_pkg::S_GAS_START;
      end
      gspe_pkg::S_GAS_START: begin
        op         = gspe_pkg::OP_GAS_START;
        state_next = st.slope_zero ? gspe_pkg::S_GAS_NEXT : gspe_pkg::S_GAS_WAIT;
      end
      gspe_pkg::S_GAS_WAIT: begin
        if (st.div_done) begin
          op         = gspe_pkg::OP_GAS_SIGN;
          state_next = gspe_pkg::S_GAS_MUL;
        end
      end
      gspe_pkg::S_GAS_MUL: begin
        op         = gspe_pkg::OP_GAS_MUL;
        state_next = gspe_pkg::S_GAS_CHECK;
      end
      gspe_pkg::S_GAS_CHECK: begin
        op         = gspe_pkg::OP_GAS_CHECK;
        state_next = (st.f_sat || st.f_small) ? gspe_pkg::S_GAS_NEXT : gspe_pkg::S_EXP;
      end
      gspe_pkg::S_EXP: begin
        op = gspe_pkg::OP_EXP_STEP;
        if (st.exp_last) begin
          state_next = gspe_pkg::S_GAS_FINISH;
        end
      end
      gspe_pkg::S_GAS_FINISH: begin
        op         = gspe_pkg::OP_GAS_FINISH;
        state_next = gspe_pkg::S_GAS_NEXT;
      end
      gspe_pkg::S_GAS_NEXT: begin
        if (st.gas_last) begin
          state_next = gspe_pkg::S_EMIT;
        end else begin
          op         = gspe_pkg::OP_GAS_NEXT;
          state_next = gspe_pkg::S_GAS_START;
        end
      end
      gspe_pkg::S_EMIT: begin
        if (st.out_free) begin
          op         = gspe_pkg::OP_EMIT;
          state_next = gspe_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = gspe_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/gas_sensor_ppm_estimator_core.sv =====
// ----------------------------------------------------------------------------
// gas_sensor_ppm_estimator_core
// Chemiresistive gas sensor estimator: averages sample resistances over
// calibration and measurement windows and reports LPG, CO and smoke ppm.
//
//   channel   signals                      beat
//   sample    sample_valid/sample_ready    req_type, adc_sample
//   result    result_valid/result_ready    status, *_ppm, ro_kohm, saturated
//   config    psel/penable/pwrite/pready   paddr, pwdata, prdata (64 bit)
//
// A sample beat is bound by the 48-step shared divider. Closing a calibration
// window adds two divisions. Closing a measurement window adds two divisions,
// a normalize pass, 16 log steps and per gas with a nonzero slope one division
// and the exponent steps unless the exponent saturates or underflows.
// Reset is synchronous; no clearing pass. A new sample beat is taken while
// the previous result waits; a full result register stalls the sequencer.
// ----------------------------------------------------------------------------
module gas_sensor_ppm_estimator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  logic [1:0]  req_type,
  input  logic [9:0]  adc_sample,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  status,
  output logic [31:0] lpg_ppm,
  output logic [31:0] co_ppm,
  output logic [31:0] smoke_ppm,
  output logic [31:0] ro_kohm,
  output logic        saturated
);

  gspe_pkg::gspe_cfg_t  cfg;
  gspe_pkg::gspe_op_t   op;
  gspe_pkg::gspe_stat_t st;
  logic                 wr_en;
  logic [2:0]           reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lpg_curve        <= '0;
      cfg.co_curve         <= '0;
      cfg.smoke_curve      <= '0;
      cfg.load_resistance  <= gspe_pkg::LOAD_RES_RESET;
      cfg.clean_air_factor <= gspe_pkg::CLEAN_AIR_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        gspe_pkg::REG_LPG_CURVE:   cfg.lpg_curve        <= pwdata[47:0];
        gspe_pkg::REG_CO_CURVE:    cfg.co_curve         <= pwdata[47:0];
        gspe_pkg::REG_SMOKE_CURVE: cfg.smoke_curve      <= pwdata[47:0];
        gspe_pkg::REG_LOAD_RES:    cfg.load_resistance  <= pwdata[15:0];
        gspe_pkg::REG_CLEAN_AIR:   cfg.clean_air_factor <= pwdata[15:0];
        default: begin
          cfg.load_resistance <= cfg.load_resistance;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      gspe_pkg::REG_LPG_CURVE:   prdata = 64'(cfg.lpg_curve);
      gspe_pkg::REG_CO_CURVE:    prdata = 64'(cfg.co_curve);
      gspe_pkg::REG_SMOKE_CURVE: prdata = 64'(cfg.smoke_curve);
      gspe_pkg::REG_LOAD_RES:    prdata = 64'(cfg.load_resistance);
      gspe_pkg::REG_CLEAN_AIR:   prdata = 64'(cfg.clean_air_factor);
      default:                   prdata = '0;
    endcase
  end

  gspe_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .st           (st),
    .op           (op)
  );

  gspe_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .cfg          (cfg),
    .st           (st),
    .req_type     (req_type),
    .adc_sample   (adc_sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .lpg_ppm      (lpg_ppm),
    .co_ppm       (co_ppm),
    .smoke_ppm    (smoke_ppm),
    .ro_kohm      (ro_kohm),
    .saturated    (saturated)
  );

endmodule

// ===== rtl/gspe_checker.sv =====
// ----------------------------------------------------------------------------
// gspe_checker
// Port-level checks of the estimator, bound to the top level.
// ----------------------------------------------------------------------------
module gspe_checker (
  input logic        clk,
  input logic        rst,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [5:0]  paddr,
  input logic [63:0] pwdata,
  input logic [63:0] prdata,
  input logic        pready,
  input logic        sample_valid,
  input logic        sample_ready,
  input logic [1:0]  req_type,
  input logic [9:0]  adc_sample,
  input logic        result_valid,
  input logic        result_ready,
  input logic [1:0]  status,
  input logic [31:0] lpg_ppm,
  input logic [31:0] co_ppm,
  input logic [31:0] smoke_ppm,
  input logic [31:0] ro_kohm,
  input logic        saturated
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(status) && $stable(lpg_ppm) && $stable(co_ppm) &&
      $stable(smoke_ppm) && $stable(ro_kohm) && $stable(saturated))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_not_cal: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == gspe_pkg::STATUS_NOT_CAL |->
      lpg_ppm == 32'd0 && co_ppm == 32'd0 && smoke_ppm == 32'd0 && !saturated)
    else $error("not-calibrated beat carries data");

  a_cal_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == gspe_pkg::STATUS_CAL_DONE |->
      lpg_ppm == 32'd0 && co_ppm == 32'd0 && smoke_ppm == 32'd0)
    else $error("calibration beat carries ppm");

endmodule

bind gas_sensor_ppm_estimator_core gspe_checker u_checker (.*);
